// File: design/led_matrix_frame_buffer_macros.svh
// ----------------------------------------------------------------------------
// LED matrix frame buffer assertion macros
// Shared clocked property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAME_BUFFER_MACROS_SVH
`define LED_MATRIX_FRAME_BUFFER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LMFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LMFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lmfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_pkg
// Constants, codes, command/status types and helpers of the frame buffer.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int NUM_ROWS   = 8;
    localparam int NUM_COLS   = 8;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int POS_W      = 8;
    localparam int KIND_W     = 2;
    localparam int DIM_W      = 4;
    localparam int OFF_W      = 3;
    localparam int ORIENT_W   = 2;
    localparam int ADDR_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    localparam logic [ORIENT_W-1:0] ORIENT_0   = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_90  = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_180 = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_270 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YOFF   = 3'd4;

    localparam logic RES_REG  = 1'b0;
    localparam logic RES_READ = 1'b1;

    typedef struct packed {
        logic             wr_pixel;
        logic             clear;
        logic             load_read;
        logic             load_row;
        logic [ROW_W-1:0] row_idx;
        logic             row_last;
    } lmfb_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic             flush_empty;
        logic [DIM_W-1:0] rows;
    } lmfb_stat_t;

    function automatic logic [NUM_COLS-1:0] reverse_bits(input logic [NUM_COLS-1:0] b);
        logic [NUM_COLS-1:0] r;
        for (int k = 0; k < NUM_COLS; k++) begin
            r[k] = b[NUM_COLS-1-k];
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(NUM_COLS)) ? DIM_W'(NUM_COLS) : v;
    endfunction

endpackage

// File: design/lmfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_ctrl
// Command decoder and flush row sequencer.
// ----------------------------------------------------------------------------
module lmfb_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [lmfb_pkg::KIND_W-1:0] s_tuser,
    input  lmfb_pkg::lmfb_stat_t       stat,
    output lmfb_pkg::lmfb_cmd_t        cmd
);
    import lmfb_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic             state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE) && stat.out_free;
        accept     = s_tvalid && s_tready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        KIND_WRITE: cmd.wr_pixel  = 1'b1;
                        KIND_READ:  cmd.load_read = 1'b1;
                        KIND_CLEAR: cmd.clear     = 1'b1;
                        KIND_FLUSH: begin
                            if (!stat.flush_empty) begin
                                state_next = ST_FLUSH;
                                row_next   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.load_row = 1'b1;
                    cmd.row_idx  = row_reg;
                    cmd.row_last = ({1'b0, row_reg} == (stat.rows - DIM_W'(1)));
                    if (cmd.row_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/lmfb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_datapath
// Config registers, pixel buffer, row rotation and the output register.
// ----------------------------------------------------------------------------
module lmfb_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [lmfb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  lmfb_pkg::lmfb_cmd_t             cmd,
    output lmfb_pkg::lmfb_stat_t            stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lmfb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import lmfb_pkg::*;

    logic [ORIENT_W-1:0] orient_reg;
    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [OFF_W-1:0]    xoff_reg, yoff_reg;

    logic [NUM_ROWS-1:0][NUM_COLS-1:0] frame_reg;

    logic                m_valid_reg;
    logic                res_kind_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [NUM_COLS-1:0] data_reg;
    logic                pix_reg;
    logic                last_reg;

    logic [POS_W-1:0]    pos_x, pos_y;
    logic                pixel_on;
    logic [POS_W:0]      col_sum, row_sum;
    logic                in_range;
    logic [ROW_W-1:0]    pix_row, pix_col;
    logic                read_bit;
    logic [DIM_W-1:0]    w_sat, h_sat, mirror_idx;
    logic [NUM_COLS-1:0] col_bits, rot90, row180, row_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg <= ORIENT_0;
            width_reg  <= DIM_W'(NUM_COLS);
            height_reg <= DIM_W'(NUM_ROWS);
            xoff_reg   <= '0;
            yoff_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ORIENT: orient_reg <= cfg_wdata[ORIENT_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_XOFF:   xoff_reg   <= cfg_wdata[OFF_W-1:0];
                CFG_YOFF:   yoff_reg   <= cfg_wdata[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign pos_x    = s_tdata[POS_W-1:0];
    assign pos_y    = s_tdata[2*POS_W-1:POS_W];
    assign pixel_on = s_tdata[2*POS_W];

    assign col_sum  = {1'b0, pos_x} + (POS_W+1)'(xoff_reg);
    assign row_sum  = {1'b0, pos_y} + (POS_W+1)'(yoff_reg);
    assign in_range = (pos_x < POS_W'(width_reg)) && (pos_y < POS_W'(height_reg))
                   && (col_sum < (POS_W+1)'(NUM_COLS)) && (row_sum < (POS_W+1)'(NUM_ROWS));
    assign pix_row  = row_sum[ROW_W-1:0];
    assign pix_col  = col_sum[ROW_W-1:0];
    assign read_bit = in_range && frame_reg[pix_row][pix_col];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
        end else if (cmd.clear) begin
            frame_reg <= '0;
        end else if (cmd.wr_pixel && in_range) begin
            frame_reg[pix_row][pix_col] <= pixel_on;
        end
    end

    // flush row formatting
    assign w_sat = sat_dim(width_reg);
    assign h_sat = sat_dim(height_reg);

    always_comb begin
        for (int n = 0; n < NUM_ROWS; n++) begin
            col_bits[n] = frame_reg[n][cmd.row_idx];
        end
    end

    // row n lands at bit w-1-n
    assign rot90      = reverse_bits(col_bits) >> (DIM_W'(NUM_COLS) - w_sat);
    assign mirror_idx = h_sat - DIM_W'(1) - DIM_W'(cmd.row_idx);
    assign row180     = reverse_bits(frame_reg[mirror_idx[ROW_W-1:0]]);

    always_comb begin
        case (orient_reg)
            ORIENT_0:   row_data = frame_reg[cmd.row_idx];
            ORIENT_90:  row_data = rot90;
            ORIENT_180: row_data = row180;
            default:    row_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_read || cmd.load_row) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_read) begin
            res_kind_reg <= RES_READ;
            addr_reg     <= '0;
            data_reg     <= '0;
            pix_reg      <= read_bit;
            last_reg     <= 1'b1;
        end else if (cmd.load_row) begin
            res_kind_reg <= RES_REG;
            addr_reg     <= ADDR_W'(cmd.row_idx) + ADDR_W'(1);
            data_reg     <= row_data;
            pix_reg      <= 1'b0;
            last_reg     <= cmd.row_last;
        end
    end

    assign stat.out_free    = !m_valid_reg || m_tready;
    assign stat.flush_empty = (orient_reg == ORIENT_270) || (h_sat == '0);
    assign stat.rows        = h_sat;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W-ADDR_W-NUM_COLS-1)'(0), pix_reg, data_reg, addr_reg};

endmodule

// File: design/led_matrix_frame_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer
// 8x8 one-bit LED frame buffer with pixel access and rotated row flush.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (kind in s_tuser); results leave on the
// m_ stream (result kind in m_tuser, final beat of a command on m_tlast).
// Registers are to be written via cfg_we/cfg_index/cfg_wdata while idle;
// the block itself does not enforce this. Pixel write and buffer clear
// produce no beat; a new command may follow in the next cycle.
// Pixel read: the reply is in the output register in the cycle after
// accept, one read per cycle while m_tready stays high.
// Flush: the row sequencer emits one beat for each of h rows
// (h = height saturated to 8, zero beats at 270 degrees or height 0);
// s_tready stays low until the last row is loaded into the output register.
// A stalled m_tready holds the output register and, through it, s_tready.
// Reset clears the pixel buffer and the output valid flag and restores the
// register defaults (0 degrees, 8x8, no offsets).
// ----------------------------------------------------------------------------
`include "led_matrix_frame_buffer_macros.svh"

module led_matrix_frame_buffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] pos_x, [15:8] pos_y, [16] pixel_on, [23:17] zero
    input  logic [lmfb_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [lmfb_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] reg_address, [11:4] reg_data, [12] pixel_value, [15:13] zero
    output logic [lmfb_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] result_kind
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import lmfb_pkg::*;

    lmfb_cmd_t  cmd;
    lmfb_stat_t stat;

    lmfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    lmfb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    `LMFB_ASSERT_NOW(a_no_accept_in_flush, cmd.load_row, !s_tready, "beat accepted during flush")
    `LMFB_ASSERT_NOW(a_load_needs_room, cmd.load_row || cmd.load_read, stat.out_free, "output register overwritten")
    `LMFB_ASSERT_NEXT(a_read_reply, cmd.load_read, m_tvalid && m_tuser == RES_READ && m_tlast && m_tdata[11:0] == 12'd0, "bad read reply")
    `LMFB_ASSERT_NOW(a_row_beat, m_tvalid && m_tuser == RES_REG, m_tdata[3:0] != 4'd0 && !m_tdata[12], "bad row beat")

endmodule

// File: dv/led_matrix_frame_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame buffer checker
// Watches the register port and both streams, keeps a shadow of the pixel
// buffer and the display registers, predicts the beats of every accepted
// command and compares each result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lmfb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [lmfb_pkg::KIND_W-1:0]     s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lmfb_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);
    import lmfb_pkg::*;

    typedef struct packed {
        logic              res_kind;
        logic [ADDR_W-1:0] digit_addr;
        logic [7:0]        digit_bits;
        logic              pixel_bit;
        logic              last;
    } display_beat_t;

    display_beat_t queued_beats[$];

    logic [NUM_COLS-1:0] pixel_rows [NUM_ROWS];
    logic [ORIENT_W-1:0] orient;
    logic [DIM_W-1:0]    disp_w;
    logic [DIM_W-1:0]    disp_h;
    logic [OFF_W-1:0]    x_off;
    logic [OFF_W-1:0]    y_off;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic bit pixel_in_view(input int px, input int py);
        if (px >= int'(disp_w) || py >= int'(disp_h)) return 1'b0;
        if (px + int'(x_off) >= NUM_COLS || py + int'(y_off) >= NUM_ROWS) return 1'b0;
        return 1'b1;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ORIENT: orient = val[ORIENT_W-1:0];
            CFG_WIDTH:  disp_w = val;
            CFG_HEIGHT: disp_h = val;
            CFG_XOFF:   x_off  = val[OFF_W-1:0];
            CFG_YOFF:   y_off  = val[OFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_command(input logic [KIND_W-1:0] kind, input logic [7:0] px,
                                 input logic [7:0] py, input logic on);
        int            row;
        int            col;
        int            nrows;
        int            ncols;
        display_beat_t b;
        logic [7:0]    bits;
        logic [7:0]    src;
        row   = int'(py) + int'(y_off);
        col   = int'(px) + int'(x_off);
        nrows = (disp_h > NUM_ROWS) ? NUM_ROWS : int'(disp_h);
        ncols = (disp_w > NUM_COLS) ? NUM_COLS : int'(disp_w);
        case (kind)
            KIND_WRITE: begin
                if (pixel_in_view(px, py)) pixel_rows[row][col] = on;
            end
            KIND_READ: begin
                b          = '0;
                b.res_kind = RES_READ;
                b.last     = 1'b1;
                if (pixel_in_view(px, py)) b.pixel_bit = pixel_rows[row][col];
                queued_beats.push_back(b);
            end
            KIND_CLEAR: begin
                for (int r = 0; r < NUM_ROWS; r++) pixel_rows[r] = '0;
            end
            default: begin
                if (orient != ORIENT_270) begin
                    for (int i = 0; i < nrows; i++) begin
                        bits = '0;
                        if (orient == ORIENT_0) begin
                            bits = pixel_rows[i];
                        end else if (orient == ORIENT_90) begin
                            // column i read top to bottom, first row ends in bit ncols-1
                            for (int n = 0; n < ncols; n++) bits = {bits[6:0], pixel_rows[n][i]};
                        end else begin
                            src = pixel_rows[nrows-1-i];
                            for (int k = 0; k < 8; k++) bits[k] = src[7-k];
                        end
                        b            = '0;
                        b.res_kind   = RES_REG;
                        b.digit_addr = ADDR_W'(i + 1);
                        b.digit_bits = bits;
                        b.last       = (i == nrows - 1);
                        queued_beats.push_back(b);
                    end
                end
            end
        endcase
    endtask

    task automatic check_beat();
        display_beat_t want;
        if (queued_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                      m_tdata, m_tuser, m_tlast));
            return;
        end
        want = queued_beats.pop_front();
        compare_field("result_kind", m_tuser, want.res_kind);
        compare_field("reg_address", m_tdata[3:0], want.digit_addr);
        compare_field("reg_data", m_tdata[11:4], want.digit_bits);
        compare_field("pixel_value", m_tdata[12], want.pixel_bit);
        compare_field("last", m_tlast, want.last);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_ROWS; r++) pixel_rows[r] = '0;
            orient = ORIENT_0;
            disp_w = DIM_W'(NUM_COLS);
            disp_h = DIM_W'(NUM_ROWS);
            x_off  = '0;
            y_off  = '0;
            queued_beats.delete();
        end else begin
            if (cfg_we) write_register(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                                    s_tdata[16]);
            if (m_tvalid && m_tready) check_beat();
        end
        pending <= queued_beats.size();
    end

endmodule

// File: dv/led_matrix_frame_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame buffer testbench
// Directed pixel, clear and flush commands, then register settings from
// empty to oversized displays in all four orientations with random commands,
// random bursts of idle on both streams and one long output stall.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_tb;
    import lmfb_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    pending;

    bit quiet     = 1'b0;
    int hold_req  = 0;
    int hold_done = 0;
    int lim_x     = 8;
    int lim_y     = 8;

    always #5 aclk = ~aclk;

    led_matrix_frame_buffer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    led_matrix_frame_buffer_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_command(input logic [KIND_W-1:0] kind, input logic [7:0] px,
                                input logic [7:0] py, input logic on);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, on, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_display(input logic [ORIENT_W-1:0] o, input logic [3:0] w,
                                input logic [3:0] h, input logic [3:0] xo,
                                input logic [3:0] yo);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        int                    sw;
        int                    sh;
        regs[0] = CFG_ORIENT; vals[0] = CFG_DATA_W'(o);
        regs[1] = CFG_WIDTH;  vals[1] = w;
        regs[2] = CFG_HEIGHT; vals[2] = h;
        regs[3] = CFG_XOFF;   vals[3] = xo;
        regs[4] = CFG_YOFF;   vals[4] = yo;
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        sw    = (w > 8) ? 8 : int'(w);
        sh    = (h > 8) ? 8 : int'(h);
        lim_x = (sw < 8 - int'(xo[2:0])) ? sw : 8 - int'(xo[2:0]);
        lim_y = (sh < 8 - int'(yo[2:0])) ? sh : 8 - int'(yo[2:0]);
    endtask

    function automatic logic [7:0] pick_pos(input int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && lim > 0) return 8'($urandom_range(0, lim - 1));
        if (r < 88) return 8'($urandom_range(0, 9));
        return 8'($urandom);
    endfunction

    task automatic send_random();
        int                r;
        logic [KIND_W-1:0] kind;
        r = $urandom_range(0, 99);
        if (r < 45) kind = KIND_WRITE;
        else if (r < 82) kind = KIND_READ;
        else if (r < 94) kind = KIND_FLUSH;
        else kind = KIND_CLEAR;
        send_command(kind, pick_pos(lim_x), pick_pos(lim_y), ($urandom_range(0, 9) < 7));
    endtask

    initial begin : m_side
        int n;
        forever begin
            if (hold_req != hold_done) begin
                m_tready <= 1'b0;
                for (int c = 0; c < 150; c++) @(posedge aclk);
                hold_done++;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [ORIENT_W-1:0] o;
        logic [3:0]          w;
        logic [3:0]          h;
        logic [3:0]          xo;
        logic [3:0]          yo;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_WRITE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset display: 8x8, no offsets, 0 deg
        send_command(KIND_WRITE, 8'd0, 8'd0, 1'b1);
        send_command(KIND_WRITE, 8'd7, 8'd7, 1'b1);
        send_command(KIND_WRITE, 8'd7, 8'd0, 1'b1);
        send_command(KIND_WRITE, 8'd0, 8'd7, 1'b1);
        send_command(KIND_WRITE, 8'd2, 8'd5, 1'b1);
        send_command(KIND_WRITE, 8'd255, 8'd255, 1'b1);
        send_command(KIND_WRITE, 8'd8, 8'd3, 1'b1);
        send_command(KIND_READ, 8'd0, 8'd0, 1'b0);
        send_command(KIND_READ, 8'd7, 8'd7, 1'b0);
        send_command(KIND_READ, 8'd255, 8'd255, 1'b1);
        send_command(KIND_READ, 8'd3, 8'd8, 1'b0);
        send_command(KIND_READ, 8'd2, 8'd5, 1'b0);
        send_command(KIND_READ, 8'd1, 8'd1, 1'b0);
        send_command(KIND_FLUSH, 8'd0, 8'd0, 1'b0);
        send_command(KIND_WRITE, 8'd2, 8'd5, 1'b0);
        send_command(KIND_READ, 8'd2, 8'd5, 1'b0);
        send_command(KIND_CLEAR, 8'd0, 8'd0, 1'b0);
        send_command(KIND_READ, 8'd7, 8'd7, 1'b0);
        send_command(KIND_FLUSH, 8'd0, 8'd0, 1'b0);
        drain();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin o = ORIENT_90;  w = 8;  h = 8;  xo = 0;  yo = 0; end
                1: begin o = ORIENT_180; w = 8;  h = 8;  xo = 0;  yo = 0; end
                2: begin o = ORIENT_270; w = 15; h = 15; xo = 7;  yo = 7; end
                3: begin o = ORIENT_0;   w = 0;  h = 0;  xo = 0;  yo = 0; end
                4: begin o = ORIENT_90;  w = 15; h = 1;  xo = 15; yo = 0; end
                5: begin o = ORIENT_180; w = 1;  h = 15; xo = 0;  yo = 7; end
                9: begin o = ORIENT_0;   w = 8;  h = 8;  xo = 3;  yo = 2; end
                default: begin
                    o  = ORIENT_W'($urandom_range(0, 3));
                    w  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
                    h  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
                    xo = 4'($urandom_range(0, 7));
                    yo = 4'($urandom_range(0, 7));
                end
            endcase
            load_display(o, w, h, xo, yo);
            if (p == 1) hold_req++;
            if (p == 9) quiet = 1'b1;
            for (int k = 0; k < 22; k++) begin
                maybe_gap();
                send_random();
            end
            maybe_gap();
            send_command(KIND_FLUSH, pick_pos(8), pick_pos(8), 1'($urandom));
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: led_matrix_frame_buffer.f
+incdir+design
design/lmfb_pkg.sv
design/lmfb_ctrl.sv
design/lmfb_datapath.sv
design/led_matrix_frame_buffer.sv
dv/led_matrix_frame_buffer_checker.sv
dv/led_matrix_frame_buffer_tb.sv
